[hw/rtl/sgb_pkg.sv]
// shared constants and types of the separable gaussian blur core
`default_nettype none
package sgb_pkg;

  parameter int MAX_RADIUS = 3;
  parameter int MAX_WIDTH  = 1024;
  parameter int MAX_HEIGHT = 1024;

  parameter int PIX_W      = 8;
  parameter int ROW_W      = 10;
  parameter int COL_OUT_W  = 10;
  parameter int WT_W       = 8;
  parameter int GEOM_W     = 11;
  parameter int RAD_W      = 2;
  parameter int NUM_W      = 19;
  parameter int DEN_W      = 11;
  parameter int CFG_IDX_W  = 3;
  parameter int CFG_DATA_W = 11;
  parameter int OUT_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 3'd0,
    CFG_W_CENTER = 3'd1,
    CFG_W_ONE    = 3'd2,
    CFG_W_TWO    = 3'd3,
    CFG_W_THREE  = 3'd4,
    CFG_WIDTH    = 3'd5,
    CFG_HEIGHT   = 3'd6
  } cfg_idx_e;

endpackage
`default_nettype wire

[hw/rtl/sgb_div.sv]
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module sgb_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [sgb_pkg::NUM_W-1:0] num_i,
  input  wire logic [sgb_pkg::DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [sgb_pkg::PIX_W-1:0]      quo_o
);

  localparam int NW = sgb_pkg::NUM_W;
  localparam int DW = sgb_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          zero_q, zero_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   shifted;
  logic          ge;

  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    ge      = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    zero_d  = zero_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      zero_d = (den_i == '0);
      cnt_d  = CW'(NW);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      zero_q <= zero_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : quo_q[sgb_pkg::PIX_W-1:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

endmodule
`default_nettype wire

[hw/rtl/separable_gaussian_blur_core.sv]
// top level of the separable gaussian blur core
// Pixels enter on the s_axis channel in raster order, one transaction per pixel.
// Blurred pixels leave on m_axis with their row and column; tlast marks the
// last result caused by one input pixel, tuser marks the bottom right pixel.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must
// write them only while idle, as the core does not enforce this. Radius and
// frame size are sampled at the first pixel of each frame.
// Each input pixel is handled alone: accept and count update, per column the
// horizontal taps, a divide and a write, per result the vertical taps, a
// divide and an output step, on the single MAC unit and bit-serial divider.
// Interior pixels give one result; row and frame ends flush bursts of up to
// 16 results. The line store holds 2*MAX_RADIUS rows of horizontal results in
// one memory with one read and one write port.
// Reset returns counters and registers to their defaults; the line store is
// not cleared, it is always written before it is read inside a frame.
// Results wait in one output register; a stalled m_axis holds the result there
// and the core stops once its next result is ready, which blocks further input.
`default_nettype none
module separable_gaussian_blur_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // pixel_in[7:0]
  input  wire logic [sgb_pkg::PIX_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // pixel_out[7:0], out_row[17:8], out_col[27:18], zero fill[31:28]
  output logic [sgb_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  // frame_done[0]
  output logic                                m_axis_tuser_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sgb_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int MAX_RADIUS = sgb_pkg::MAX_RADIUS;
  localparam int MAX_WIDTH  = sgb_pkg::MAX_WIDTH;
  localparam int WIN_LEN    = 2 * MAX_RADIUS + 1;
  localparam int STORE_ROWS = 2 * MAX_RADIUS;
  localparam int IDX_W      = $clog2(WIN_LEN);
  localparam int SLOT_W     = $clog2(STORE_ROWS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = $clog2(STORE_ROWS * MAX_WIDTH);
  localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int CS_W       = COL_W + 3;
  localparam int RS_W       = sgb_pkg::ROW_W + 3;
  localparam int GW         = sgb_pkg::GEOM_W;
  localparam int RW         = sgb_pkg::ROW_W;
  localparam int PW         = sgb_pkg::PIX_W;
  localparam int AW         = sgb_pkg::NUM_W;
  localparam int WW         = sgb_pkg::DEN_W;
  localparam int TAP_W      = 3;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_HTAP  = 9'b000000010,
    S_HDIV  = 9'b000000100,
    S_VTAP  = 9'b000001000,
    S_VACC  = 9'b000010000,
    S_VDIV  = 9'b000100000,
    S_OUT   = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  // configuration registers
  logic [sgb_pkg::RAD_W-1:0] radius_q;
  logic [sgb_pkg::WT_W-1:0]  w_center_q, w_one_q, w_two_q, w_three_q;
  logic [GW-1:0]             width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= 2'd3;
      w_center_q <= 8'd13;
      w_one_q    <= 8'd9;
      w_two_q    <= 8'd4;
      w_three_q  <= 8'd1;
      width_q    <= 11'd640;
      height_q   <= 11'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sgb_pkg::CFG_RADIUS:   radius_q   <= cfg_wdata_i[sgb_pkg::RAD_W-1:0];
        sgb_pkg::CFG_W_CENTER: w_center_q <= cfg_wdata_i[sgb_pkg::WT_W-1:0];
        sgb_pkg::CFG_W_ONE:    w_one_q    <= cfg_wdata_i[sgb_pkg::WT_W-1:0];
        sgb_pkg::CFG_W_TWO:    w_two_q    <= cfg_wdata_i[sgb_pkg::WT_W-1:0];
        sgb_pkg::CFG_W_THREE:  w_three_q  <= cfg_wdata_i[sgb_pkg::WT_W-1:0];
        sgb_pkg::CFG_WIDTH:    width_q    <= cfg_wdata_i;
        sgb_pkg::CFG_HEIGHT:   height_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e                    state_q, state_d;
  logic [RW-1:0]             row_q, row_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic [SLOT_W-1:0]         slot_q, slot_d;
  logic [sgb_pkg::RAD_W-1:0] lat_r_q, lat_r_d;
  logic [GW-1:0]             lat_w_q, lat_w_d, lat_h_q, lat_h_d;
  logic [PW-1:0]             win_q [WIN_LEN];
  logic                      shift_en;
  logic [COL_W-1:0]          c_q, c_d, chi_q, chi_d;
  logic [RW-1:0]             y_q, y_d, ylo_q, ylo_d, yhi_q, yhi_d;
  logic                      rows_q, rows_d, last_col_q, last_col_d, last_row_q, last_row_d;
  logic [TAP_W-1:0]          tap_q, tap_d;
  logic [AW-1:0]             acc_q, acc_d;
  logic [WW-1:0]             wsum_q, wsum_d;
  logic [PW-1:0]             h_q, h_d;
  logic                      vok_q, vok_d, vself_q, vself_d;
  logic [sgb_pkg::WT_W-1:0]  vwt_q, vwt_d;
  logic [PW-1:0]             o_pix_q, o_pix_d;
  logic                      o_last_q, o_last_d, o_done_q, o_done_d;
  logic [PW-1:0]             line_mem [DEPTH];
  logic [PW-1:0]             rd_q;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic                      mem_rd, mem_wr;
  logic                      div_start, div_done;
  logic [PW-1:0]             div_quo;
  logic [AW-1:0]             div_num;
  logic                      out_vld_q, out_load, out_last_q, out_user_q;
  logic [sgb_pkg::OUT_DATA_W-1:0] out_data_q;

  // geometry seen by the pixel being accepted
  logic                      first_px, last_col_n, last_row_n, any_n, rows_n;
  logic [sgb_pkg::RAD_W-1:0] r_n;
  logic [GW-1:0]             w_n, h_n;
  logic [COL_W-1:0]          clo_n, chi_n;
  logic [RW-1:0]             ylo_n;

  always_comb begin
    first_px = (row_q == '0) && (col_q == '0);
    r_n = lat_r_q;
    w_n = lat_w_q;
    h_n = lat_h_q;
    if (first_px) begin
      r_n = (int'(radius_q) > MAX_RADIUS) ? sgb_pkg::RAD_W'(MAX_RADIUS) : radius_q;
      w_n = (width_q == '0) ? GW'(1) :
            ((int'(width_q) > MAX_WIDTH) ? GW'(MAX_WIDTH) : width_q);
      h_n = (height_q == '0) ? GW'(1) :
            ((int'(height_q) > sgb_pkg::MAX_HEIGHT) ? GW'(sgb_pkg::MAX_HEIGHT) : height_q);
    end
    last_col_n = ((GW+2)'(col_q) + (GW+2)'(1)) >= (GW+2)'(w_n);
    last_row_n = ((GW+2)'(row_q) + (GW+2)'(1)) >= (GW+2)'(h_n);
    any_n = 1'b1;
    if (last_col_n) begin
      clo_n = (col_q >= COL_W'(r_n)) ? col_q - COL_W'(r_n) : '0;
      chi_n = col_q;
    end else if (col_q >= COL_W'(r_n)) begin
      clo_n = col_q - COL_W'(r_n);
      chi_n = clo_n;
    end else begin
      clo_n = '0;
      chi_n = '0;
      any_n = 1'b0;
    end
    rows_n = 1'b1;
    if (last_row_n) begin
      ylo_n = (row_q >= RW'(r_n)) ? row_q - RW'(r_n) : '0;
    end else if (row_q >= RW'(r_n)) begin
      ylo_n = row_q - RW'(r_n);
    end else begin
      ylo_n = '0;
      rows_n = 1'b0;
    end
  end

  // tap offset and weight
  logic signed [CS_W-1:0]    k_s, x_s, idx_s;
  logic signed [RS_W-1:0]    kr_s, yy_s, d_s;
  logic [TAP_W-1:0]          absk;
  logic [sgb_pkg::WT_W-1:0]  tap_wt;
  logic                      h_ok, v_ok, v_self;
  logic [SLOT_W:0]           slot_sum;
  logic [SLOT_W-1:0]         rd_slot;
  logic                      last_tap;

  always_comb begin
    k_s   = CS_W'(tap_q) - CS_W'(lat_r_q);
    kr_s  = RS_W'(tap_q) - RS_W'(lat_r_q);
    absk  = (k_s < 0) ? TAP_W'(-k_s) : TAP_W'(k_s);
    case (absk)
      3'd0:    tap_wt = w_center_q;
      3'd1:    tap_wt = w_one_q;
      3'd2:    tap_wt = w_two_q;
      3'd3:    tap_wt = w_three_q;
      default: tap_wt = '0;
    endcase
    x_s   = CS_W'(c_q) + k_s;
    idx_s = CS_W'(col_q) - x_s;
    h_ok  = (x_s >= 0) && (x_s < CS_W'(lat_w_q)) && (idx_s >= 0) &&
            (idx_s < CS_W'(WIN_LEN));
    yy_s   = RS_W'(y_q) + kr_s;
    d_s    = RS_W'(row_q) - yy_s;
    v_ok   = (yy_s >= 0) && (yy_s < RS_W'(lat_h_q)) && (d_s >= 0) &&
             (d_s <= RS_W'(STORE_ROWS));
    v_self = (d_s == '0);
    slot_sum = (SLOT_W+1)'(slot_q) + (SLOT_W+1)'(STORE_ROWS) - (SLOT_W+1)'(d_s);
    rd_slot  = (slot_sum >= (SLOT_W+1)'(STORE_ROWS)) ?
               SLOT_W'(slot_sum - (SLOT_W+1)'(STORE_ROWS)) : SLOT_W'(slot_sum);
    last_tap = (tap_q == {lat_r_q, 1'b0});
  end

  assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_q);
  assign wr_addr = ADDR_W'(slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_q);
  assign mem_rd  = (state_q == S_VTAP);
  assign mem_wr  = (state_q == S_WRITE);

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      line_mem[wr_addr] <= h_q;
    end
    if (mem_rd) begin
      rd_q <= line_mem[rd_addr];
    end
  end

  assign div_start = ((state_q == S_HTAP) || (state_q == S_VACC)) && last_tap;
  assign div_num   = AW'(acc_d + AW'(wsum_d) - AW'(1));

  sgb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (wsum_d),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic [PW-1:0] v_pix;
  assign v_pix = vself_q ? h_q : rd_q;

  always_comb begin
    state_d = state_q;
    row_d = row_q; col_d = col_q; slot_d = slot_q;
    lat_r_d = lat_r_q; lat_w_d = lat_w_q; lat_h_d = lat_h_q;
    c_d = c_q; chi_d = chi_q; y_d = y_q; ylo_d = ylo_q; yhi_d = yhi_q;
    rows_d = rows_q; last_col_d = last_col_q; last_row_d = last_row_q;
    tap_d = tap_q; acc_d = acc_q; wsum_d = wsum_q; h_d = h_q;
    vok_d = vok_q; vself_d = vself_q; vwt_d = vwt_q;
    o_pix_d = o_pix_q; o_last_d = o_last_q; o_done_d = o_done_q;
    shift_en = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          shift_en = 1'b1;
          lat_r_d = r_n; lat_w_d = w_n; lat_h_d = h_n;
          if (first_px) slot_d = '0;
          last_col_d = last_col_n; last_row_d = last_row_n;
          c_d = clo_n; chi_d = chi_n;
          ylo_d = ylo_n;
          yhi_d = last_row_n ? row_q : ylo_n;
          rows_d = rows_n;
          tap_d = '0; acc_d = '0; wsum_d = '0;
          state_d = any_n ? S_HTAP : S_DONE;
        end
      end
      S_HTAP: begin
        if (h_ok) begin
          acc_d  = acc_q + AW'(tap_wt * win_q[idx_s[IDX_W-1:0]]);
          wsum_d = wsum_q + WW'(tap_wt);
        end
        tap_d = tap_q + 1'b1;
        if (last_tap) state_d = S_HDIV;
      end
      S_HDIV: begin
        if (div_done) begin
          h_d = div_quo;
          y_d = ylo_q; tap_d = '0; acc_d = '0; wsum_d = '0;
          state_d = rows_q ? S_VTAP : S_WRITE;
        end
      end
      S_VTAP: begin
        vok_d = v_ok; vself_d = v_self; vwt_d = tap_wt;
        state_d = S_VACC;
      end
      S_VACC: begin
        if (vok_q) begin
          acc_d  = acc_q + AW'(vwt_q * v_pix);
          wsum_d = wsum_q + WW'(vwt_q);
        end
        tap_d = tap_q + 1'b1;
        state_d = last_tap ? S_VDIV : S_VTAP;
      end
      S_VDIV: begin
        if (div_done) begin
          o_pix_d  = div_quo;
          o_last_d = (c_q == chi_q) && (y_q == yhi_q);
          o_done_d = ((GW'(y_q) + GW'(1)) == lat_h_q) &&
                     ((GW'(c_q) + GW'(1)) == lat_w_q);
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          if (y_q == yhi_q) begin
            state_d = S_WRITE;
          end else begin
            y_d = y_q + 1'b1; tap_d = '0; acc_d = '0; wsum_d = '0;
            state_d = S_VTAP;
          end
        end
      end
      S_WRITE: begin
        if (c_q == chi_q) begin
          state_d = S_DONE;
        end else begin
          c_d = c_q + 1'b1; tap_d = '0; acc_d = '0; wsum_d = '0;
          state_d = S_HTAP;
        end
      end
      S_DONE: begin
        if (last_col_q) begin
          col_d = '0;
          if (last_row_q) begin
            row_d = '0; slot_d = '0;
          end else begin
            row_d = row_q + 1'b1;
            slot_d = (slot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q <= '0; col_q <= '0; slot_q <= '0;
      lat_r_q <= '0; lat_w_q <= GW'(1); lat_h_q <= GW'(1);
      for (int i = 0; i < WIN_LEN; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      row_q <= row_d; col_q <= col_d; slot_q <= slot_d;
      lat_r_q <= lat_r_d; lat_w_q <= lat_w_d; lat_h_q <= lat_h_d;
      if (shift_en) begin
        for (int i = WIN_LEN - 1; i > 0; i--) win_q[i] <= win_q[i-1];
        win_q[0] <= s_axis_tdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; chi_q <= chi_d; y_q <= y_d; ylo_q <= ylo_d; yhi_q <= yhi_d;
    rows_q <= rows_d; last_col_q <= last_col_d; last_row_q <= last_row_d;
    tap_q <= tap_d; acc_q <= acc_d; wsum_q <= wsum_d; h_q <= h_d;
    vok_q <= vok_d; vself_q <= vself_d; vwt_q <= vwt_d;
    o_pix_q <= o_pix_d; o_last_q <= o_last_d; o_done_q <= o_done_d;
  end

  // output register
  assign out_load = (state_q == S_OUT) && (!out_vld_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {4'b0000, sgb_pkg::COL_OUT_W'(c_q), y_q, o_pix_q};
      out_last_q <= o_last_q;
      out_user_q <= o_done_q;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
    (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("frame end result not last of run");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second pixel taken without processing");

endmodule
`default_nettype wire
